// ===== src/fvn_pkg.sv =====
// fvn_pkg: shared constants for the fractal value noise pipeline
// permutation rom contents and reciprocal table for the octave normalization
// no dependencies
package fvn_pkg;

	// fixed point layout of the lattice coordinate (Q8.16)
	localparam int LAT_BITS  = 24;
	localparam int FRAC_BITS = 16;

	// configuration register indexes
	localparam logic [1:0] REG_FREQUENCY = 2'd0;
	localparam logic [1:0] REG_OCTAVES   = 2'd1;
	localparam logic [1:0] REG_SEED      = 2'd2;

	// hash permutation table
	localparam logic [7:0] PERM_ROM [256] = '{
		8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,  8'd161, 8'd78,
		8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
		8'd40,  8'd185, 8'd248, 8'd251, 8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,
		8'd36,  8'd1,   8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
		8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174, 8'd173, 8'd102,
		8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44,  8'd43,  8'd77,
		8'd180, 8'd204, 8'd8,   8'd81,  8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254,
		8'd210, 8'd210, 8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
		8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,   8'd47,  8'd104,
		8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
		8'd70,  8'd180, 8'd174, 8'd0,   8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116,
		8'd127, 8'd198, 8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
		8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
		8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195, 8'd38,  8'd58,  8'd65,  8'd207,
		8'd215, 8'd253, 8'd65,  8'd85,  8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,
		8'd89,  8'd232, 8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
		8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
		8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97,  8'd53,  8'd145, 8'd135,
		8'd19,  8'd103, 8'd13,  8'd90,  8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247,
		8'd33,  8'd39,  8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
		8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158, 8'd42,  8'd30,
		8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
		8'd115, 8'd184, 8'd21,  8'd233, 8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128,
		8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
		8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250, 8'd209, 8'd92,
		8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
	};

	// floor(2^32 / (2^d - 1)) for d = 1..16; d = 1 uses all ones and relies on the
	// correction step, entry 0 is never used
	localparam logic [31:0] RECIP [17] = '{
		32'd0,          32'hFFFF_FFFF, 32'd1431655765, 32'd613566756,
		32'd286331153,  32'd138547332, 32'd68174084,   32'd33818640,
		32'd16843009,   32'd8405024,   32'd4198404,    32'd2098176,
		32'd1048832,    32'd524352,    32'd262160,     32'd131076,
		32'd65537
	};

endpackage

// ===== src/fvn_octave.sv =====
// fvn_octave: one octave lane, lattice hash, smoothstep weights and bilinear blend
// four register stages (_s2 to _s5); depends on fvn_pkg
module fvn_octave import fvn_pkg::*; #(
	parameter int OCT_IDX = 0
) (
	input  logic                clk,
	input  logic                en,
	input  logic [LAT_BITS-1:0] px,
	input  logic [LAT_BITS-1:0] py,
	input  logic [7:0]          seed,
	output logic [LAT_BITS-1:0] n
);

	logic [LAT_BITS-1:0] cx, cy;
	logic [7:0]  xi, yi, ra_idx, rb_idx;
	logic [15:0] fx, fy;

	logic [7:0]  xi_s2, ra_s2, rb_s2;
	logic [15:0] fx_s2, fy_s2;
	logic [31:0] ffx_s2, ffy_s2;

	logic [49:0] wxp, wyp;
	logic [7:0]  h00_s3, h10_s3, h01_s3, h11_s3;
	logic [15:0] wx_s3, wy_s3;

	logic [23:0] lo_s4, hi_s4;
	logic [15:0] wy_s4;

	logic [40:0] blend;
	logic [23:0] n_s5;

	// lattice position of this octave
	assign cx     = LAT_BITS'(px << OCT_IDX);
	assign cy     = LAT_BITS'(py << OCT_IDX);
	assign xi     = cx[LAT_BITS-1:FRAC_BITS];
	assign yi     = cy[LAT_BITS-1:FRAC_BITS];
	assign fx     = cx[FRAC_BITS-1:0];
	assign fy     = cy[FRAC_BITS-1:0];
	assign ra_idx = 8'(yi + seed);
	assign rb_idx = 8'(yi + seed + 8'd1);

	// row hash and squared fractions
	always_ff @(posedge clk) begin
		if (en) begin
			xi_s2  <= xi;
			ra_s2  <= PERM_ROM[ra_idx];
			rb_s2  <= PERM_ROM[rb_idx];
			fx_s2  <= fx;
			fy_s2  <= fy;
			ffx_s2 <= 32'(fx) * 32'(fx);
			ffy_s2 <= 32'(fy) * 32'(fy);
		end
	end

	// smoothstep: f*f*(3 - 2f)
	assign wxp = 50'(ffx_s2) * 50'(18'h30000 - {1'b0, fx_s2, 1'b0});
	assign wyp = 50'(ffy_s2) * 50'(18'h30000 - {1'b0, fy_s2, 1'b0});

	// corner hashes and weights
	always_ff @(posedge clk) begin
		if (en) begin
			h00_s3 <= PERM_ROM[8'(ra_s2 + xi_s2)];
			h10_s3 <= PERM_ROM[8'(ra_s2 + xi_s2 + 8'd1)];
			h01_s3 <= PERM_ROM[8'(rb_s2 + xi_s2)];
			h11_s3 <= PERM_ROM[8'(rb_s2 + xi_s2 + 8'd1)];
			wx_s3  <= wxp[47:32];
			wy_s3  <= wyp[47:32];
		end
	end

	// row blends along x, exact in Q8.16
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4 <= 24'((25'h10000 - 25'(wx_s3)) * 25'(h00_s3) + 25'(wx_s3) * 25'(h10_s3));
			hi_s4 <= 24'((25'h10000 - 25'(wx_s3)) * 25'(h01_s3) + 25'(wx_s3) * 25'(h11_s3));
			wy_s4 <= wy_s3;
		end
	end

	// column blend along y
	assign blend = (41'h10000 - 41'(wy_s4)) * 41'(lo_s4) + 41'(wy_s4) * 41'(hi_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5 <= blend[39:16];
		end
	end

	assign n = n_s5;

endmodule

// ===== src/fvn_div.sv =====
// fvn_div: divides the octave sum by (2^d - 1) through a reciprocal multiply
// two register stages (_s7, _s8) with a single correction step; depends on fvn_pkg
module fvn_div import fvn_pkg::*; #(
	parameter int MAX_OCTAVES = 8,
	parameter int DW          = $clog2(MAX_OCTAVES + 1),
	parameter int TW          = 16 + MAX_OCTAVES
) (
	input  logic          clk,
	input  logic          en,
	input  logic [TW-1:0] t,
	input  logic [DW-1:0] d,
	output logic [15:0]   q
);

	logic [TW+31:0] prod;
	logic [TW-1:0]  q0_s7, t_s7;
	logic [DW-1:0]  d_s7;
	logic [TW:0]    q0m, rem, m;
	logic [TW-1:0]  qc;
	logic [15:0]    q_s8;

	// estimate, never more than one below the true quotient
	assign prod = (TW+32)'(t) * (TW+32)'(RECIP[5'(d)]);

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s7 <= prod[TW+31:32];
			t_s7  <= t;
			d_s7  <= d;
		end
	end

	// remainder check with shift and subtract
	assign m   = ((TW+1)'(1) << d_s7) - (TW+1)'(1);
	assign q0m = ((TW+1)'(q0_s7) << d_s7) - (TW+1)'(q0_s7);
	assign rem = (TW+1)'(t_s7) - q0m;
	assign qc  = (rem >= m) ? TW'(q0_s7 + TW'(1)) : q0_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s8 <= qc[15:0];
		end
	end

	assign q = q_s8;

endmodule

// ===== src/fractal_value_noise_2d.sv =====
// Fractal value noise over a 2D coordinate, one sample per clock cycle while the output is not stalled.
// One stage scales the coordinate by the frequency, four stages per octave lane do hashing,
// smoothstep and blending (all octaves run in parallel lanes), one stage sums the
// octaves and two stages normalize by 256*(2^d-1) with a reciprocal multiply.
// The whole pipeline moves unless a valid output is stalled. Configuration is
// sampled with each transaction at the first stage.
// depends on fvn_pkg, fvn_octave and fvn_div
module fractal_value_noise_2d import fvn_pkg::*; #(
	parameter int MAX_OCTAVES = 8,
	parameter int COORD_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] x_pos,
	input  logic [15:0] y_pos,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] noise_value
);

	localparam int DW = $clog2(MAX_OCTAVES + 1);
	localparam int SW = LAT_BITS + MAX_OCTAVES;
	localparam int TW = SW - 8;

	logic [15:0] frequency_q;
	logic [3:0]  octave_count_q;
	logic [7:0]  seed_q;

	logic        adv;
	logic [15:0] coord_mask;
	logic [DW-1:0] d_sel;
	logic [31:0] px_full, py_full;

	logic [LAT_BITS-1:0] px_s1, py_s1;
	logic [7:0]  seed_s1;
	logic [DW-1:0] d_s1, d_s2, d_s3, d_s4, d_s5, d_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_valid_q;

	logic [LAT_BITS-1:0] lane_n [MAX_OCTAVES];
	logic [SW-1:0] acc;
	logic [TW-1:0] t_s6;

	// register writes and reads
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frequency_q    <= 16'd6554;
			octave_count_q <= 4'd4;
			seed_q         <= 8'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_FREQUENCY: frequency_q    <= pwdata[15:0];
				REG_OCTAVES:   octave_count_q <= pwdata[3:0];
				REG_SEED:      seed_q         <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FREQUENCY: prdata = {16'd0, frequency_q};
			REG_OCTAVES:   prdata = {28'd0, octave_count_q};
			REG_SEED:      prdata = {24'd0, seed_q};
			default:       prdata = 32'd0;
		endcase
	end

	// pipeline advance
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// octave count clamp and coordinate scaling
	assign coord_mask = (COORD_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << COORD_BITS) - 17'd1);

	always_comb begin
		if (octave_count_q == 4'd0) begin
			d_sel = DW'(1);
		end else if (32'(octave_count_q) > MAX_OCTAVES) begin
			d_sel = DW'(MAX_OCTAVES);
		end else begin
			d_sel = DW'(octave_count_q);
		end
	end

	assign px_full = 32'(x_pos & coord_mask) * 32'(frequency_q);
	assign py_full = 32'(y_pos & coord_mask) * 32'(frequency_q);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	// payload chain
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= px_full[LAT_BITS-1:0];
			py_s1   <= py_full[LAT_BITS-1:0];
			seed_s1 <= seed_q;
			d_s1    <= d_sel;
			d_s2    <= d_s1;
			d_s3    <= d_s2;
			d_s4    <= d_s3;
			d_s5    <= d_s4;
		end
	end

	// octave lanes
	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
		fvn_octave #(
			.OCT_IDX(k)
		) u_octave (
			.clk  (clk),
			.en   (adv),
			.px   (px_s1),
			.py   (py_s1),
			.seed (seed_s1),
			.n    (lane_n[k])
		);
	end

	// weighted octave sum, octave i scaled by 2^(d-1-i)
	always_comb begin
		acc = '0;
		for (int k = 0; k < MAX_OCTAVES; k++) begin
			if (k < 32'(d_s5)) begin
				acc = acc + (SW'(lane_n[k]) << (32'(d_s5) - 32'(k) - 1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s6 <= acc[SW-1:8];
			d_s6 <= d_s5;
		end
	end

	// normalization
	fvn_div #(
		.MAX_OCTAVES(MAX_OCTAVES),
		.DW(DW),
		.TW(TW)
	) u_div (
		.clk (clk),
		.en  (adv),
		.t   (t_s6),
		.d   (d_s6),
		.q   (noise_value)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== src/fvn_checker.sv =====
// fvn_checker: port level checks for fractal_value_noise_2d
// bound to the top level; no package dependency
module fvn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] noise_value
);

	// a stalled result stays presented
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(noise_value))
		else $error("stalled result changed");

	// input backpressure only comes from a blocked output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	// normalized noise never reaches 255/256 plus one step
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> noise_value <= 16'd65280)
		else $error("noise value out of range");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.noise_value (noise_value)
);

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for fractal_value_noise_2d
// drives sample transactions and apb register writes, predicts noise values
// depends on fvn_pkg and the fractal_value_noise_2d rtl
`timescale 1ns / 100ps

class noise_scoreboard;
	logic [15:0] pending_noise[$];
	int errors;

	function void note_sample(logic [15:0] expected);
		pending_noise.insert(pending_noise.size(), expected);
	endfunction

	function void check_noise(logic [15:0] actual);
		logic [15:0] expected;
		if (pending_noise.size() == 0) begin
			$display("%0t: unexpected noise_value, expected none, actual %0d", $time, actual);
			errors++;
			return;
		end
		expected = pending_noise.pop_front();
		if (expected !== actual) begin
			$display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, expected,
				actual);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import fvn_pkg::*;

	localparam int OCT_LIMIT = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] x_pos = '0, y_pos = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] noise_value;

	// model copy of the configuration registers
	logic [15:0] cfg_freq;
	logic [3:0]  cfg_octaves;
	logic [7:0]  cfg_seed;

	int send_idle_pct, stall_pct;
	int cycle_count;
	noise_scoreboard sb;

	fractal_value_noise_2d DUT (.*);

	always #6 clk = ~clk;

	// smoothstep weight in Q0.16
	function automatic logic [63:0] smooth(logic [63:0] f);
		return (f * f * ((64'd3 << 16) - 64'd2 * f)) >> 32;
	endfunction

	function automatic logic [63:0] lattice_byte(logic [7:0] col, logic [7:0] row);
		logic [7:0] h;
		h = PERM_ROM[8'(row + cfg_seed)];
		return 64'(PERM_ROM[8'(h + col)]);
	endfunction

	// expected normalized noise for one coordinate under the current configuration
	function automatic logic [15:0] predict_noise(logic [15:0] xp, logic [15:0] yp);
		logic [63:0] px, py, cx, cy, wx, wy, lo, hi, total;
		logic [7:0]  xi, yi;
		int d;
		px = 64'(xp) * 64'(cfg_freq);
		py = 64'(yp) * 64'(cfg_freq);
		d = cfg_octaves;
		if (d == 0) d = 1;
		if (d > OCT_LIMIT) d = OCT_LIMIT;
		total = 0;
		for (int i = 0; i < d; i++) begin
			cx = (px << i) & 64'hFFFFFF;
			cy = (py << i) & 64'hFFFFFF;
			xi = cx[23:16];
			yi = cy[23:16];
			wx = smooth(cx & 64'hFFFF);
			wy = smooth(cy & 64'hFFFF);
			lo = (64'd65536 - wx) * lattice_byte(xi, yi) + wx * lattice_byte(xi + 8'd1, yi);
			hi = (64'd65536 - wx) * lattice_byte(xi, yi + 8'd1)
				+ wx * lattice_byte(xi + 8'd1, yi + 8'd1);
			total += (((64'd65536 - wy) * lo + wy * hi) >> 16) << (d - 1 - i);
		end
		return 16'(total / (64'd256 * ((64'd1 << d) - 64'd1)));
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stall and checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_noise(noise_value);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 4'(idx) << 2; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_FREQUENCY: cfg_freq = value[15:0];
			REG_OCTAVES:   cfg_octaves = value[3:0];
			REG_SEED:      cfg_seed = value[7:0];
			default: ;
		endcase
		// return to idle before the next transfer
		@(posedge clk);
	endtask

	// wait for every result, then let the pipeline settle
	task automatic drain();
		while (sb.pending_noise.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send_sample(logic [15:0] xp, logic [15:0] yp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1; x_pos <= xp; y_pos <= yp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(predict_noise(xp, yp));
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small coordinates, some full range
	function automatic logic [15:0] rand_coord();
		return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
	endfunction

	initial begin
		logic [15:0] freqs[6];
		int idle_tbl[4], stall_tbl[4];
		sb = new();
		cycle_count = 0;
		cfg_freq = 16'd6554; cfg_octaves = 4'd4; cfg_seed = 8'd1;
		send_idle_pct = 0; stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: coordinate extremes at reset settings
		send_sample(16'd0, 16'd0);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'hFFFF, 16'd0);
		send_sample(16'd0, 16'hFFFF);
		send_sample(16'h5555, 16'hAAAA);
		send_sample(16'hAAAA, 16'h5555);
		end_burst();
		drain();
		// octave count zero, above max, and max with frequency extremes
		apb_write(REG_OCTAVES, 32'd0);
		apb_write(REG_FREQUENCY, 32'hFFFF);
		apb_write(REG_SEED, 32'hFF);
		send_sample(16'hFFFF, 16'h1234);
		send_sample(16'd1, 16'd1);
		end_burst();
		drain();
		apb_write(REG_OCTAVES, 32'hF);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'd7, 16'd300);
		end_burst();
		drain();
		apb_write(REG_OCTAVES, 32'd8);
		apb_write(REG_FREQUENCY, 32'd0);
		send_sample(16'hFFFF, 16'hFFFF);
		end_burst();
		drain();
		apb_write(REG_FREQUENCY, 32'd1);
		apb_write(REG_OCTAVES, 32'd1);
		apb_write(REG_SEED, 32'd0);
		send_sample(16'hFFFF, 16'h8000);
		send_sample(16'h8000, 16'hFFFF);
		end_burst();
		drain();
		// unused register address is ignored
		apb_write(2'd3, 32'hFFFF_FFFF);
		send_sample(16'd1000, 16'd2000);
		end_burst();
		drain();

		// random phases with different idling and configurations
		freqs = '{16'd6554, 16'hFFFF, 16'd1, 16'd300, 16'h8000, 16'd20000};
		idle_tbl = '{0, 77, 0, 23};
		stall_tbl = '{0, 0, 77, 23};
		for (int ph = 0; ph < 8; ph++) begin
			apb_write(REG_FREQUENCY, (ph < 6) ? 32'(freqs[ph]) : 32'($urandom_range(65535)));
			apb_write(REG_OCTAVES, 32'($urandom_range(15)));
			apb_write(REG_SEED, 32'($urandom_range(255)));
			send_idle_pct = idle_tbl[ph % 4];
			stall_pct = stall_tbl[ph % 4];
			for (int n = 0; n < 215; n++) begin
				send_sample(rand_coord(), rand_coord());
				// pause until everything has come out
				if (n == 100) begin
					end_burst();
					while (sb.pending_noise.size() != 0) @(posedge clk);
				end
			end
			end_burst();
			send_idle_pct = 0;
			stall_pct = 0;
			drain();
		end

		if (sb.errors == 0 && sb.pending_noise.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
